// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ssp_pkg.sv =====
// constants, types and the saturating adder of the shortest path block
// no dependencies
package ssp_pkg;

    localparam int NODES    = 256;
    localparam int EDGES    = 1024;
    localparam int NODE_W   = $clog2(NODES);
    localparam int EDGE_W   = $clog2(EDGES);
    localparam int NCOUNT_W = NODE_W + 1;
    localparam int ECOUNT_W = EDGE_W + 1;
    localparam int DIST_W   = 32;
    localparam int WEIGHT_W = 16;
    localparam int ROUND_W  = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // input modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT = 1'b1;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = NCOUNT_W'(NODES);
    localparam logic [ECOUNT_W-1:0] EDGE_COUNT_RESET = '0;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // one edge table entry: from in the low byte, weight in the top half
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]          to_node;
        logic [NODE_W-1:0]          from_node;
    } edge_t;

    // distance plus weight, clamped to the signed 32-bit range
    function automatic logic signed [DIST_W-1:0] sat_add(
        input logic signed [DIST_W-1:0]   base,
        input logic signed [WEIGHT_W-1:0] step
    );
        logic signed [DIST_W:0] total;
        logic signed [DIST_W-1:0] res;
        total = {base[DIST_W-1], base}
              + {{(DIST_W+1-WEIGHT_W){step[WEIGHT_W-1]}}, step};
        if (total[DIST_W] != total[DIST_W-1])
        begin
            res = total[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            res = total[DIST_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/single_source_shortest_path.sv =====
// Edge write: accepted when idle. Query: the search runs in rounds until a round changes
// no distance or the round bound is reached; each round the edge table read port
// streams one edge per cycle through a read, relax and write-back pipeline.
// One transaction at a time; a finished result waits in an output register.
// Reset (async, active low) clears control and the distance valid flags, node_count 256.
// holds the top level: config port, edge table, distance memory, relax pipeline
// depends on ssp_pkg and assert_macros.svh
`include "assert_macros.svh"

module single_source_shortest_path (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ssp_pkg::ADDR_W-1:0]            paddr,
    input  logic [ssp_pkg::DATA_W-1:0]            pwdata,
    output logic [ssp_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  mode,
    input  logic [ssp_pkg::EDGE_W-1:0]            edge_index,
    input  logic [ssp_pkg::NODE_W-1:0]            edge_from,
    input  logic [ssp_pkg::NODE_W-1:0]            edge_to,
    input  logic signed [ssp_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic [ssp_pkg::NODE_W-1:0]            source_node,
    input  logic [ssp_pkg::NODE_W-1:0]            target_node,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [ssp_pkg::DIST_W-1:0]     path_distance,
    output logic                                  reachable,
    output logic [ssp_pkg::ROUND_W-1:0]           rounds_used
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_RDRES  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    // memories
    ssp_pkg::edge_t                      edge_mem [ssp_pkg::EDGES];
    logic signed [ssp_pkg::DIST_W-1:0]   dist_mem [ssp_pkg::NODES];

    // control and data registers
    logic [2:0]                          state_reg, state_next;
    logic [ssp_pkg::NCOUNT_W-1:0]        node_count_reg, node_count_next;
    logic [ssp_pkg::ECOUNT_W-1:0]        edge_count_reg, edge_count_next;
    logic [ssp_pkg::NCOUNT_W-1:0]        n_reg, n_next;
    logic [ssp_pkg::ECOUNT_W-1:0]        m_reg, m_next;
    logic [ssp_pkg::NODE_W-1:0]          dst_reg, dst_next;
    logic [ssp_pkg::ROUND_W-1:0]         round_reg, round_next;
    logic [ssp_pkg::ECOUNT_W-1:0]        ptr_reg, ptr_next;
    logic                                changed_reg, changed_next;
    logic                                s1_v_reg, s1_v_next;
    logic                                s2_v_reg, s2_v_next;
    ssp_pkg::edge_t                      s2_edge_reg, s2_edge_next;
    logic [ssp_pkg::NODES-1:0]           dvalid_reg, dvalid_next;
    logic                                last_we_reg, last_we_next;
    logic [ssp_pkg::NODE_W-1:0]          last_addr_reg, last_addr_next;
    logic signed [ssp_pkg::DIST_W-1:0]   last_data_reg, last_data_next;
    logic                                result_valid_reg, result_valid_next;
    logic signed [ssp_pkg::DIST_W-1:0]   path_distance_reg, path_distance_next;
    logic                                reachable_reg, reachable_next;
    logic [ssp_pkg::ROUND_W-1:0]         rounds_used_reg, rounds_used_next;
    ssp_pkg::edge_t                      edge_rdata_reg;
    logic signed [ssp_pkg::DIST_W-1:0]   dist_a_reg, dist_b_reg;

    // combinational signals
    logic                                cfg_write;
    logic                                item_take;
    logic [ssp_pkg::NCOUNT_W-1:0]        n_calc;
    logic [ssp_pkg::ECOUNT_W-1:0]        m_calc;
    logic                                edge_we;
    logic                                edge_re;
    logic                                dist_we;
    logic [ssp_pkg::NODE_W-1:0]          dist_waddr;
    logic signed [ssp_pkg::DIST_W-1:0]   dist_wdata;
    logic                                dist_re;
    logic [ssp_pkg::NODE_W-1:0]          dist_raddr_a;
    logic signed [ssp_pkg::DIST_W-1:0]   dist_a_fwd;
    logic signed [ssp_pkg::DIST_W-1:0]   dist_b_fwd;
    logic signed [ssp_pkg::DIST_W-1:0]   cand;
    logic                                skip;
    logic                                relax;
    logic                                run_issue;
    logic                                run_done;
    logic                                target_reach;
    logic                                out_free;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            ssp_pkg::REG_NODE_COUNT: prdata = ssp_pkg::DATA_W'(node_count_reg);
            ssp_pkg::REG_EDGE_COUNT: prdata = ssp_pkg::DATA_W'(edge_count_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        node_count_next = node_count_reg;
        edge_count_next = edge_count_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                ssp_pkg::REG_NODE_COUNT: node_count_next = pwdata[ssp_pkg::NCOUNT_W-1:0];
                ssp_pkg::REG_EDGE_COUNT: edge_count_next = pwdata[ssp_pkg::ECOUNT_W-1:0];
                default:                 node_count_next = node_count_reg;
            endcase
        end
    end

    // clamp the counts to the table sizes, and a node count of zero to one
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_calc = ssp_pkg::NCOUNT_W'(1);
        end
        else if (node_count_reg > ssp_pkg::NCOUNT_W'(ssp_pkg::NODES))
        begin
            n_calc = ssp_pkg::NCOUNT_W'(ssp_pkg::NODES);
        end
        else
        begin
            n_calc = node_count_reg;
        end
        if (edge_count_reg > ssp_pkg::ECOUNT_W'(ssp_pkg::EDGES))
        begin
            m_calc = ssp_pkg::ECOUNT_W'(ssp_pkg::EDGES);
        end
        else
        begin
            m_calc = edge_count_reg;
        end
    end

    // input handshake
    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign edge_we    = item_take && (mode == ssp_pkg::MODE_WRITE);

    // edge issue and round completion
    assign run_issue = (state_reg == ST_RUN) && (ptr_reg < m_reg);
    assign run_done  = (state_reg == ST_RUN) && !run_issue && !s1_v_reg && !s2_v_reg;
    assign edge_re   = run_issue;

    // relax stage with forwarding of the previous cycle's write-back
    always_comb
    begin
        dist_a_fwd = dist_a_reg;
        dist_b_fwd = dist_b_reg;
        if (last_we_reg && (last_addr_reg == s2_edge_reg.from_node))
        begin
            dist_a_fwd = last_data_reg;
        end
        if (last_we_reg && (last_addr_reg == s2_edge_reg.to_node))
        begin
            dist_b_fwd = last_data_reg;
        end
        cand  = ssp_pkg::sat_add(dist_a_fwd, s2_edge_reg.weight);
        skip  = ({1'b0, s2_edge_reg.from_node} >= n_reg)
             || ({1'b0, s2_edge_reg.to_node} >= n_reg)
             || !dvalid_reg[s2_edge_reg.from_node];
        relax = s2_v_reg && !skip
             && (!dvalid_reg[s2_edge_reg.to_node] || (cand < dist_b_fwd));
    end

    // distance memory port selection
    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = s2_edge_reg.to_node;
        dist_wdata = cand;
        if (item_take && (mode == ssp_pkg::MODE_QUERY))
        begin
            dist_we    = 1'b1;
            dist_waddr = source_node;
            dist_wdata = '0;
        end
        else if (relax)
        begin
            dist_we = 1'b1;
        end
        dist_re      = s1_v_reg || (state_reg == ST_RDRES);
        dist_raddr_a = (state_reg == ST_RDRES) ? dst_reg : edge_rdata_reg.from_node;
    end

    // result of the query
    assign target_reach = ({1'b0, dst_reg} < n_reg) && dvalid_reg[dst_reg];
    assign out_free     = !result_valid_reg || !result_stall;

    // sequencer and pipeline
    always_comb
    begin
        state_next         = state_reg;
        n_next             = n_reg;
        m_next             = m_reg;
        dst_next           = dst_reg;
        round_next         = round_reg;
        ptr_next           = ptr_reg;
        changed_next       = changed_reg;
        s1_v_next          = run_issue;
        s2_v_next          = s1_v_reg;
        s2_edge_next       = edge_rdata_reg;
        dvalid_next        = dvalid_reg;
        last_we_next       = relax;
        last_addr_next     = s2_edge_reg.to_node;
        last_data_next     = cand;
        result_valid_next  = result_valid_reg && result_stall;
        path_distance_next = path_distance_reg;
        reachable_next     = reachable_reg;
        rounds_used_next   = rounds_used_reg;

        if (relax)
        begin
            dvalid_next[s2_edge_reg.to_node] = 1'b1;
            changed_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take && (mode == ssp_pkg::MODE_QUERY))
                begin
                    n_next      = n_calc;
                    m_next      = m_calc;
                    dst_next    = target_node;
                    round_next  = '0;
                    dvalid_next = '0;
                    if ({1'b0, source_node} < n_calc)
                    begin
                        dvalid_next[source_node] = 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((ssp_pkg::NCOUNT_W'(round_reg) + ssp_pkg::NCOUNT_W'(1)) < n_reg)
                begin
                    changed_next = 1'b0;
                    ptr_next     = '0;
                    state_next   = ST_RUN;
                end
                else
                begin
                    state_next = ST_RDRES;
                end
            end
            ST_RUN:
            begin
                if (run_issue)
                begin
                    ptr_next = ptr_reg + ssp_pkg::ECOUNT_W'(1);
                end
                if (run_done)
                begin
                    round_next = round_reg + ssp_pkg::ROUND_W'(1);
                    state_next = changed_reg ? ST_CHECK : ST_RDRES;
                end
            end
            ST_RDRES:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    reachable_next     = target_reach;
                    path_distance_next = target_reach ? dist_a_reg : '0;
                    rounds_used_next   = round_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            node_count_reg   <= ssp_pkg::NODE_COUNT_RESET;
            edge_count_reg   <= ssp_pkg::EDGE_COUNT_RESET;
            round_reg        <= '0;
            ptr_reg          <= '0;
            changed_reg      <= 1'b0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            dvalid_reg       <= '0;
            last_we_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            node_count_reg   <= node_count_next;
            edge_count_reg   <= edge_count_next;
            round_reg        <= round_next;
            ptr_reg          <= ptr_next;
            changed_reg      <= changed_next;
            s1_v_reg         <= s1_v_next;
            s2_v_reg         <= s2_v_next;
            dvalid_reg       <= dvalid_next;
            last_we_reg      <= last_we_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg             <= n_next;
        m_reg             <= m_next;
        dst_reg           <= dst_next;
        s2_edge_reg       <= s2_edge_next;
        last_addr_reg     <= last_addr_next;
        last_data_reg     <= last_data_next;
        path_distance_reg <= path_distance_next;
        reachable_reg     <= reachable_next;
        rounds_used_reg   <= rounds_used_next;
    end

    // edge table
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_index] <= '{weight: edge_weight, to_node: edge_to,
                                      from_node: edge_from};
        end
        if (edge_re)
        begin
            edge_rdata_reg <= edge_mem[ptr_reg[ssp_pkg::EDGE_W-1:0]];
        end
    end

    // distance memory, one write and two reads
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re)
        begin
            dist_a_reg <= dist_mem[dist_raddr_a];
            dist_b_reg <= dist_mem[edge_rdata_reg.to_node];
        end
    end

    // outputs
    assign result_valid  = result_valid_reg;
    assign path_distance = path_distance_reg;
    assign reachable     = reachable_reg;
    assign rounds_used   = rounds_used_reg;

    // checks
    `ASSERT_IMPLIES(a_round_bound, clk, rst_n, state_reg == ST_RUN,
        (ssp_pkg::NCOUNT_W'(round_reg) + ssp_pkg::NCOUNT_W'(1)) < n_reg)
    `ASSERT_IMPLIES(a_ptr_bound, clk, rst_n, state_reg == ST_RUN, ptr_reg <= m_reg)
    `ASSERT_NEXT(a_pipe_flow, clk, rst_n, s1_v_reg, s2_v_reg)
    `ASSERT_IMPLIES(a_result_load, clk, rst_n, $rose(result_valid_reg),
        $past(state_reg) == ST_RESULT)

endmodule

// ===== dv/single_source_shortest_path_test.sv =====
`timescale 1ns / 1ps
// testbench for single_source_shortest_path: edge writes and path queries checked
// against a bellman-ford predictor, with apb register setup and random stalls
// depends on ssp_pkg and the rtl top level single_source_shortest_path

module single_source_shortest_path_test;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 190;
    localparam int FILL_SLOTS = 64;

    // one input transaction
    typedef struct {
        logic                                mode;
        logic [ssp_pkg::EDGE_W-1:0]          slot;
        logic [ssp_pkg::NODE_W-1:0]          from_node;
        logic [ssp_pkg::NODE_W-1:0]          to_node;
        logic signed [ssp_pkg::WEIGHT_W-1:0] weight;
        logic [ssp_pkg::NODE_W-1:0]          source;
        logic [ssp_pkg::NODE_W-1:0]          target;
    } graph_item_t;

    // one query answer
    typedef struct {
        logic signed [ssp_pkg::DIST_W-1:0] distance;
        logic                              reach;
        logic [ssp_pkg::ROUND_W-1:0]       rounds;
    } path_answer_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [ssp_pkg::ADDR_W-1:0]          paddr;
    logic [ssp_pkg::DATA_W-1:0]          pwdata;
    logic [ssp_pkg::DATA_W-1:0]          prdata;
    logic                                pready;
    logic                                item_valid;
    logic                                item_stall;
    logic                                mode;
    logic [ssp_pkg::EDGE_W-1:0]          edge_index;
    logic [ssp_pkg::NODE_W-1:0]          edge_from;
    logic [ssp_pkg::NODE_W-1:0]          edge_to;
    logic signed [ssp_pkg::WEIGHT_W-1:0] edge_weight;
    logic [ssp_pkg::NODE_W-1:0]          source_node;
    logic [ssp_pkg::NODE_W-1:0]          target_node;
    logic                                result_valid;
    logic                                result_stall;
    logic signed [ssp_pkg::DIST_W-1:0]   path_distance;
    logic                                reachable;
    logic [ssp_pkg::ROUND_W-1:0]         rounds_used;

    // local copy of the edge table and the registers
    logic [ssp_pkg::NODE_W-1:0]          edge_from_copy [ssp_pkg::EDGES];
    logic [ssp_pkg::NODE_W-1:0]          edge_to_copy [ssp_pkg::EDGES];
    logic signed [ssp_pkg::WEIGHT_W-1:0] edge_weight_copy [ssp_pkg::EDGES];
    logic [ssp_pkg::NCOUNT_W-1:0]        node_count_copy;
    logic [ssp_pkg::ECOUNT_W-1:0]        edge_count_copy;

    path_answer_t pending_answers [$];
    path_answer_t oldest_answer;
    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int hold_off_request = 0;
    int hold_off_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    single_source_shortest_path dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .edge_index    (edge_index),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_weight   (edge_weight),
        .source_node   (source_node),
        .target_node   (target_node),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .path_distance (path_distance),
        .reachable     (reachable),
        .rounds_used   (rounds_used)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("single_source_shortest_path_test failed");
            $finish;
        end
    end

    // bellman-ford over the local edge table, in place, with early stop
    function automatic path_answer_t shortest_path(input logic [ssp_pkg::NODE_W-1:0] src,
                                                   input logic [ssp_pkg::NODE_W-1:0] dst);
        int n;
        int m;
        int rounds;
        int a;
        int b;
        int node_dist [ssp_pkg::NODES];
        bit known [ssp_pkg::NODES];
        bit changed;
        longint cand;
        path_answer_t ans;
        n = node_count_copy;
        if (n < 1)
            n = 1;
        if (n > ssp_pkg::NODES)
            n = ssp_pkg::NODES;
        m = edge_count_copy;
        if (m > ssp_pkg::EDGES)
            m = ssp_pkg::EDGES;
        foreach (node_dist[i])
        begin
            node_dist[i] = 0;
            known[i] = 1'b0;
        end
        if (src < n)
            known[src] = 1'b1;
        rounds = 0;
        while (rounds + 1 < n)
        begin
            changed = 1'b0;
            for (int e = 0; e < m; e++)
            begin
                a = edge_from_copy[e];
                b = edge_to_copy[e];
                // skip edges off the active nodes or out of an unreached node
                if (a < n && b < n && known[a])
                begin
                    cand = longint'(node_dist[a]) + longint'(edge_weight_copy[e]);
                    if (cand > longint'(ssp_pkg::DIST_MAX))
                        cand = longint'(ssp_pkg::DIST_MAX);
                    if (cand < longint'(ssp_pkg::DIST_MIN))
                        cand = longint'(ssp_pkg::DIST_MIN);
                    if (!known[b] || cand < longint'(node_dist[b]))
                    begin
                        known[b] = 1'b1;
                        node_dist[b] = int'(cand);
                        changed = 1'b1;
                    end
                end
            end
            rounds++;
            if (!changed)
                break;
        end
        ans.reach = (dst < n) && known[dst];
        ans.distance = ans.reach ? node_dist[dst] : 0;
        ans.rounds = ssp_pkg::ROUND_W'(rounds);
        return ans;
    endfunction

    // sender: bursts with random gaps, prediction on acceptance
    task automatic send_item(input graph_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid  <= 1'b1;
        mode        <= item.mode;
        edge_index  <= item.slot;
        edge_from   <= item.from_node;
        edge_to     <= item.to_node;
        edge_weight <= item.weight;
        source_node <= item.source;
        target_node <= item.target;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        // transaction taken at this edge
        if (item.mode == ssp_pkg::MODE_WRITE)
        begin
            edge_from_copy[item.slot] = item.from_node;
            edge_to_copy[item.slot] = item.to_node;
            edge_weight_copy[item.slot] = item.weight;
        end
        else
        begin
            pending_answers.insert(pending_answers.size(),
                                   shortest_path(item.source, item.target));
        end
    endtask

    task automatic write_edge(input int slot, input int from_node, input int to_node,
                              input int weight);
        graph_item_t item;
        item.mode = ssp_pkg::MODE_WRITE;
        item.slot = ssp_pkg::EDGE_W'(slot);
        item.from_node = ssp_pkg::NODE_W'(from_node);
        item.to_node = ssp_pkg::NODE_W'(to_node);
        item.weight = ssp_pkg::WEIGHT_W'(weight);
        item.source = ssp_pkg::NODE_W'($urandom);
        item.target = ssp_pkg::NODE_W'($urandom);
        send_item(item);
    endtask

    task automatic run_query(input int src, input int dst);
        graph_item_t item;
        item.mode = ssp_pkg::MODE_QUERY;
        item.slot = ssp_pkg::EDGE_W'($urandom);
        item.from_node = ssp_pkg::NODE_W'($urandom);
        item.to_node = ssp_pkg::NODE_W'($urandom);
        item.weight = ssp_pkg::WEIGHT_W'($urandom);
        item.source = ssp_pkg::NODE_W'(src);
        item.target = ssp_pkg::NODE_W'(dst);
        send_item(item);
    endtask

    // drop valid and wait for every answer, then let a write finish
    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // apb setup and access phases; psel left high for a following write
    task automatic set_register(input logic idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ssp_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= ssp_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == ssp_pkg::REG_NODE_COUNT)
            node_count_copy = ssp_pkg::NCOUNT_W'(value);
        else
            edge_count_copy = ssp_pkg::ECOUNT_W'(value);
    endtask

    task automatic configure(input int unsigned nodes, input int unsigned edges);
        wait_idle();
        set_register(ssp_pkg::REG_NODE_COUNT, nodes);
        set_register(ssp_pkg::REG_EDGE_COUNT, edges);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int random_node(input int n);
        return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
    endfunction

    function automatic int random_weight();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return $urandom_range(0, 65535);
        if (pick == 1)
            return $urandom_range(0, 120) - 20;
        return $urandom_range(0, 100);
    endfunction

    function automatic int random_slot(input int edges);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, ssp_pkg::EDGES - 1);
        return $urandom_range(0, edges + 2);
    endfunction

    // low slots written once: forward edges grouped by start node, so a
    // query over them settles in two rounds
    task automatic test_fill_edge_table();
        int f;
        int t;
        for (int slot = 0; slot < FILL_SLOTS; slot++)
        begin
            f = slot >> 2;
            t = (f == 255) ? 255 : $urandom_range(f + 1, 255);
            write_edge(slot, f, t, $urandom_range(0, 32767));
        end
    endtask

    // register extremes, including node counts beyond the legal range
    task automatic test_register_extremes();
        configure(256, FILL_SLOTS);
        run_query(0, 255);
        run_query(0, $urandom_range(1, 254));
        run_query(255, 0);
        configure(511, FILL_SLOTS);
        run_query(0, 128);
        configure(0, FILL_SLOTS);
        run_query(0, 0);
        run_query(3, 3);
        configure(256, 0);
        run_query(7, 7);
    endtask

    // negative self loops drive node 0 past the signed range
    task automatic test_saturation();
        for (int slot = 0; slot < 260; slot++)
            write_edge(slot, 0, 0, -32767);
        write_edge(260, 0, 1, -32768);
        configure(256, 261);
        run_query(0, 1);
    endtask

    // small hand-built graph covering the special cases
    task automatic test_directed_graph();
        write_edge(0, 0, 1, 32767);
        write_edge(1, 1, 2, -32768);
        write_edge(2, 3, 4, 5);
        write_edge(3, 2, 7, 1);
        write_edge(4, 0, 2, 100);
        write_edge(5, 255, 0, 0);
        configure(6, 6);
        run_query(0, 2);
        run_query(0, 4);
        run_query(0, 7);
        run_query(200, 1);
        run_query(0, 0);
        run_query(3, 4);
        // single node
        configure(1, 6);
        run_query(0, 0);
        // negative cycle between nodes 1 and 2
        write_edge(6, 2, 1, -5);
        configure(6, 7);
        run_query(0, 1);
        run_query(0, 5);
    endtask

    // receiver holds off while queries pile up, then the sender drains
    task automatic test_pressure();
        configure(10, 16);
        for (int slot = 0; slot < 16; slot++)
            write_edge(slot, random_node(10), random_node(10), random_weight());
        hold_off_request = 400;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                write_edge($urandom_range(16, 40), random_node(10), random_node(10),
                           random_weight());
            else
                run_query(random_node(10), random_node(10));
        end
        wait_idle();
        for (int i = 0; i < 6; i++)
            run_query(random_node(10), random_node(10));
    endtask

    // phases of random writes and queries under random register settings
    task automatic test_random_traffic();
        int sent;
        int pick;
        int nodes;
        int edges;
        int n;
        int phase_len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                nodes = 1;
                edges = $urandom_range(0, 24);
            end
            else if (pick == 1)
            begin
                nodes = 256;
                edges = $urandom_range(0, 8);
            end
            else if (pick == 2)
            begin
                nodes = $urandom_range(257, 511);
                edges = $urandom_range(0, 8);
            end
            else
            begin
                nodes = $urandom_range(2, 12);
                edges = $urandom_range(0, 24);
            end
            configure(nodes, edges);
            n = (nodes > ssp_pkg::NODES) ? ssp_pkg::NODES : nodes;
            phase_len = $urandom_range(10, 40);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) < 55)
                    write_edge(random_slot(edges), random_node(n), random_node(n),
                               random_weight());
                else
                    run_query(random_node(n), random_node(n));
                sent++;
            end
        end
    endtask

    // receiver stall: long hold-off on request, else a pattern per stretch
    always @(posedge clk)
    begin
        if (hold_off_request > 0)
        begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_stall <= 1'b1;
        end
        else if (stall_mode == 0)
            result_stall <= 1'b0;
        else if (stall_mode == 1)
            result_stall <= ($urandom_range(0, 2) == 0);
        else
            result_stall <= ($urandom_range(0, 3) != 0);
    end

    // result check against the oldest pending answer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d %0b %0d",
                         $time, path_distance, reachable, rounds_used);
            end
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (path_distance !== oldest_answer.distance)
                begin
                    mismatches++;
                    $display("%0t: path_distance expected %0d actual %0d",
                             $time, oldest_answer.distance, path_distance);
                end
                if (reachable !== oldest_answer.reach)
                begin
                    mismatches++;
                    $display("%0t: reachable expected %0b actual %0b",
                             $time, oldest_answer.reach, reachable);
                end
                if (rounds_used !== oldest_answer.rounds)
                begin
                    mismatches++;
                    $display("%0t: rounds_used expected %0d actual %0d",
                             $time, oldest_answer.rounds, rounds_used);
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        mode         <= ssp_pkg::MODE_WRITE;
        edge_index   <= '0;
        edge_from    <= '0;
        edge_to      <= '0;
        edge_weight  <= '0;
        source_node  <= '0;
        target_node  <= '0;
        result_stall <= 1'b0;
        node_count_copy = ssp_pkg::NODE_COUNT_RESET;
        edge_count_copy = ssp_pkg::EDGE_COUNT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_edge_table();
        test_register_extremes();
        test_saturation();
        test_directed_graph();
        test_pressure();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("single_source_shortest_path_test passed");
        else
            $display("single_source_shortest_path_test failed");
        $finish;
    end

endmodule
